// ----- src/mdt_pkg.sv -----
// Package for the maximum drawdown tracker: widths, payload types, controller
// states and the command and status words between controller and datapath.
// Depends on nothing; every other file of the block imports it.
package mdt_pkg;

   localparam int EQUITY_BITS   = 32;
   localparam int INDEX_BITS    = 20;
   localparam int FRACTION_BITS = 16;
   localparam int DIV_CNT_BITS  = $clog2(FRACTION_BITS);

   typedef logic [EQUITY_BITS-1:0]   equity_type;
   typedef logic [INDEX_BITS-1:0]    index_type;
   typedef logic [FRACTION_BITS-1:0] fraction_type;
   typedef logic [DIV_CNT_BITS-1:0]  div_cnt_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_DIV,
      ST_COMMIT
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic div_init;
      logic div_step;
      logic commit;
   } mdt_cmd_type;

   typedef struct packed {
      logic above_peak;
      logic out_busy;
   } mdt_status_type;

   function automatic index_type sat_inc(input index_type value);
      sat_inc = (value == '1) ? value : index_type'(value + 1'b1);
   endfunction

endpackage

// ----- src/mdt_if.sv -----
// Valid/ready channel interfaces for the drawdown tracker's sample and result words.
// Depends on mdt_pkg for the payload types.
interface mdt_req_if;
   import mdt_pkg::*;

   logic       valid;
   logic       ready;
   equity_type equity;
   logic       first_sample;

   modport source(output valid, equity, first_sample, input ready);
   modport sink(input valid, equity, first_sample, output ready);
endinterface

interface mdt_rsp_if;
   import mdt_pkg::*;

   logic         valid;
   logic         ready;
   fraction_type worst_dd;
   index_type    dd_peak_idx;
   index_type    dd_trough_idx;
   index_type    dd_recovery_idx;
   index_type    longest_underwater;

   modport source(output valid, worst_dd, dd_peak_idx, dd_trough_idx, dd_recovery_idx,
                  longest_underwater, input ready);
   modport sink(input valid, worst_dd, dd_peak_idx, dd_trough_idx, dd_recovery_idx,
                longest_underwater, output ready);
endinterface

// ----- src/mdt_ctrl.sv -----
// Controller state machine of the drawdown tracker: sequences accept, compare,
// the radix-2 division and the commit. Depends on mdt_pkg.
module mdt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mdt_pkg::mdt_status_type status,
   output mdt_pkg::mdt_cmd_type    cmd
);
   import mdt_pkg::*;

   ctrl_state_type state_ff, state_in;
   div_cnt_type    cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CMP;
         end
         ST_CMP: begin
            state_in = status.above_peak ? ST_COMMIT : ST_DIV;
         end
         ST_DIV: begin
            if (cnt_ff == div_cnt_type'(FRACTION_BITS - 1)) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (!status.out_busy) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      cnt_in       = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = !reset;
            cmd.accept = req_valid && !reset;
         end
         ST_CMP: begin
            cmd.div_init = !status.above_peak;
            cnt_in       = '0;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = div_cnt_type'(cnt_ff + 1'b1);
         end
         ST_COMMIT: begin
            cmd.commit = !status.out_busy;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ----- src/mdt_datapath.sv -----
// Datapath of the drawdown tracker: curve state, restoring divider and
// the result register. Depends on mdt_pkg; driven by mdt_ctrl commands.
module mdt_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  mdt_pkg::mdt_cmd_type        cmd,
   output mdt_pkg::mdt_status_type     status,
   input  mdt_pkg::equity_type         req_equity,
   input  logic                        req_first_sample,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output mdt_pkg::fraction_type       rsp_worst_dd,
   output mdt_pkg::index_type          rsp_dd_peak_idx,
   output mdt_pkg::index_type          rsp_dd_trough_idx,
   output mdt_pkg::index_type          rsp_dd_recovery_idx,
   output mdt_pkg::index_type          rsp_longest_underwater
);
   import mdt_pkg::*;

   equity_type   eq_ff;
   equity_type   peak_ff, peak_in;
   index_type    peak_idx_ff, peak_idx_in;
   index_type    count_ff, count_in;
   fraction_type worst_ff, worst_in;
   index_type    wpi_ff, wpi_in;
   index_type    wti_ff, wti_in;
   index_type    rec_ff, rec_in;
   logic         await_ff, await_in;
   index_type    cur_uw_ff, cur_uw_in;
   index_type    longest_ff, longest_in;
   equity_type   rem_ff, rem_in;
   fraction_type quo_ff, quo_in;
   logic         rsp_valid_ff;
   fraction_type out_dd_ff;
   index_type    out_pi_ff, out_ti_ff, out_ri_ff, out_lu_ff;

   logic [EQUITY_BITS:0] rem_sh;
   logic                 rem_ge;
   logic                 clear_state;

   assign clear_state       = cmd.accept && req_first_sample;
   assign status.above_peak = (eq_ff >= peak_ff);
   assign status.out_busy   = rsp_valid_ff && !rsp_ready;

   // One quotient bit per step; the remainder never exceeds the peak.
   assign rem_sh = {rem_ff, 1'b0};
   assign rem_ge = (rem_sh >= {1'b0, peak_ff});

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.div_init) begin
         rem_in = peak_ff - eq_ff;
         quo_in = '0;
      end else if (cmd.div_step) begin
         rem_in = rem_ge ? equity_type'(rem_sh - {1'b0, peak_ff}) : equity_type'(rem_sh);
         quo_in = {quo_ff[FRACTION_BITS-2:0], rem_ge};
      end
   end

   always_comb begin
      peak_in     = peak_ff;
      peak_idx_in = peak_idx_ff;
      worst_in    = worst_ff;
      wpi_in      = wpi_ff;
      wti_in      = wti_ff;
      rec_in      = rec_ff;
      await_in    = await_ff;
      cur_uw_in   = cur_uw_ff;
      longest_in  = longest_ff;
      count_in    = sat_inc(count_ff);
      if (status.above_peak) begin
         peak_in     = eq_ff;
         peak_idx_in = count_ff;
         cur_uw_in   = '0;
         if (await_ff) begin
            rec_in   = count_ff;
            await_in = 1'b0;
         end
      end else begin
         cur_uw_in = sat_inc(cur_uw_ff);
         if (cur_uw_in > longest_ff) longest_in = cur_uw_in;
         if (quo_ff > worst_ff) begin
            worst_in = quo_ff;
            wpi_in   = peak_idx_ff;
            wti_in   = count_ff;
            rec_in   = count_ff;
            await_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear_state) begin
         peak_ff     <= '0;
         peak_idx_ff <= '0;
         count_ff    <= '0;
         worst_ff    <= '0;
         wpi_ff      <= '0;
         wti_ff      <= '0;
         rec_ff      <= '0;
         await_ff    <= 1'b0;
         cur_uw_ff   <= '0;
         longest_ff  <= '0;
      end else if (cmd.commit) begin
         peak_ff     <= peak_in;
         peak_idx_ff <= peak_idx_in;
         count_ff    <= count_in;
         worst_ff    <= worst_in;
         wpi_ff      <= wpi_in;
         wti_ff      <= wti_in;
         rec_ff      <= rec_in;
         await_ff    <= await_in;
         cur_uw_ff   <= cur_uw_in;
         longest_ff  <= longest_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) eq_ff <= req_equity;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (cmd.commit) begin
         out_dd_ff <= worst_in;
         out_pi_ff <= wpi_in;
         out_ti_ff <= wti_in;
         out_ri_ff <= rec_in;
         out_lu_ff <= longest_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_worst_dd           = out_dd_ff;
   assign rsp_dd_peak_idx        = out_pi_ff;
   assign rsp_dd_trough_idx      = out_ti_ff;
   assign rsp_dd_recovery_idx    = out_ri_ff;
   assign rsp_longest_underwater = out_lu_ff;

   assert property (@(posedge clock) disable iff (reset) cmd.commit |-> !status.out_busy)
      else $error("Result committed over a word that was not taken.");

   assert property (@(posedge clock) disable iff (reset) cmd.commit |=> rsp_valid_ff)
      else $error("Commit did not present a result word.");

   assert property (@(posedge clock) disable iff (reset)
      (worst_ff != '0) |-> (wti_ff >= wpi_ff && rec_ff >= wti_ff))
      else $error("Drawdown indices out of order.");

   assert property (@(posedge clock) disable iff (reset) await_ff |-> (rec_ff == wti_ff))
      else $error("Recovery index moved before the peak was regained.");

   assert property (@(posedge clock) disable iff (reset) (worst_ff == '0) |-> !await_ff)
      else $error("Waiting for recovery without a recorded drawdown.");

endmodule

// ----- src/max_drawdown_tracker.sv -----
// Top level of the maximum drawdown tracker: joins controller and datapath to
// the sample and result channels. Depends on mdt_pkg, mdt_if, mdt_ctrl, mdt_datapath.
//
//   Channel   Direction  Word
//   req_ch    in         equity (32 b), first_sample (1 b)
//   rsp_ch    out        worst_dd (16 b), dd_peak/trough/recovery_idx,
//                        longest_underwater (20 b each)
//
// A sample at or above the running peak passes through accept, compare and commit.
// A sample below the peak also runs the restoring divider, one quotient bit per cycle,
// between compare and commit; a new sample is taken only after the last one commits.
// Reset is synchronous; the state clears in the reset cycle, no clearing pass.
// A finished word waits in the output register while the next sample is taken;
// the commit of that next sample stalls until the waiting word is taken.
module max_drawdown_tracker (
   input logic      clock,
   input logic      reset,
   mdt_req_if.sink  req_ch,
   mdt_rsp_if.source rsp_ch
);
   import mdt_pkg::*;

   mdt_cmd_type    cmd;
   mdt_status_type status;

   mdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mdt_datapath u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .req_equity             (req_ch.equity),
      .req_first_sample       (req_ch.first_sample),
      .rsp_valid              (rsp_ch.valid),
      .rsp_ready              (rsp_ch.ready),
      .rsp_worst_dd           (rsp_ch.worst_dd),
      .rsp_dd_peak_idx        (rsp_ch.dd_peak_idx),
      .rsp_dd_trough_idx      (rsp_ch.dd_trough_idx),
      .rsp_dd_recovery_idx    (rsp_ch.dd_recovery_idx),
      .rsp_longest_underwater (rsp_ch.longest_underwater)
   );

endmodule

// ----- tb/mdt_drawdown_check.sv -----
`timescale 1ns / 100ps
// Checker for the maximum drawdown tracker: watches the sample and result channels,
// predicts every result word from the accepted samples and compares whole words.
// Depends on mdt_pkg for widths and types and on mdt_if for the channel interfaces.
module mdt_drawdown_check (
   input  logic clock,
   input  logic reset,
   mdt_req_if   req_mon,
   mdt_rsp_if   rsp_mon,
   output int   error_count,
   output int   words_pending
);
   import mdt_pkg::*;

   localparam int WIDE_BITS    = EQUITY_BITS + FRACTION_BITS;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      fraction_type worst_dd;
      index_type    dd_peak_idx;
      index_type    dd_trough_idx;
      index_type    dd_recovery_idx;
      index_type    longest_underwater;
   } drawdown_word_type;

   equity_type        peak_level;
   index_type         peak_pos;
   index_type         next_pos;
   index_type         worst_peak_pos;
   index_type         worst_trough_pos;
   index_type         recovery_pos;
   index_type         underwater_run;
   index_type         longest_run;
   fraction_type      worst_fraction;
   logic              recovery_pending;
   drawdown_word_type expected_words[$];
   int                failures = 0;

   function automatic index_type bump_index(input index_type value);
      return (value == '1) ? value : index_type'(value + 1'b1);
   endfunction

   function automatic fraction_type drawdown_fraction(input equity_type peak,
                                                      input equity_type level);
      logic [WIDE_BITS-1:0] quotient;
      quotient = {equity_type'(peak - level), {FRACTION_BITS{1'b0}}} / WIDE_BITS'(peak);
      // A sample of zero makes the whole peak the numerator, and the divider
      // then returns all ones instead of wrapping.
      return (quotient > {FRACTION_BITS{1'b1}}) ? '1 : quotient[FRACTION_BITS-1:0];
   endfunction

   function automatic string describe(input drawdown_word_type word);
      return $sformatf("dd %h peak %h trough %h recovery %h longest %h", word.worst_dd,
                       word.dd_peak_idx, word.dd_trough_idx, word.dd_recovery_idx,
                       word.longest_underwater);
   endfunction

   task automatic clear_curve();
      peak_level       = '0;
      peak_pos         = '0;
      next_pos         = '0;
      worst_peak_pos   = '0;
      worst_trough_pos = '0;
      recovery_pos     = '0;
      underwater_run   = '0;
      longest_run      = '0;
      worst_fraction   = '0;
      recovery_pending = 1'b0;
   endtask

   task automatic track_sample(input equity_type level, input logic first,
                               output drawdown_word_type word);
      index_type    pos;
      fraction_type fraction;
      if (first) begin
         clear_curve();
      end
      pos = next_pos;
      if (level >= peak_level) begin
         peak_level     = level;
         peak_pos       = pos;
         underwater_run = '0;
         if (recovery_pending) begin
            recovery_pos     = pos;
            recovery_pending = 1'b0;
         end
      end else begin
         underwater_run = bump_index(underwater_run);
         if (underwater_run > longest_run) begin
            longest_run = underwater_run;
         end
         fraction = drawdown_fraction(peak_level, level);
         if (fraction > worst_fraction) begin
            worst_fraction   = fraction;
            worst_peak_pos   = peak_pos;
            worst_trough_pos = pos;
            recovery_pos     = pos;
            recovery_pending = 1'b1;
         end
      end
      next_pos = bump_index(pos);
      word.worst_dd           = worst_fraction;
      word.dd_peak_idx        = worst_peak_pos;
      word.dd_trough_idx      = worst_trough_pos;
      word.dd_recovery_idx    = recovery_pos;
      word.longest_underwater = longest_run;
   endtask

   always @(posedge clock) begin
      drawdown_word_type predicted;
      drawdown_word_type observed;
      if (reset) begin
         clear_curve();
         expected_words.delete();
      end else begin
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            track_sample(req_mon.equity, req_mon.first_sample, predicted);
            expected_words.push_back(predicted);
         end
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            observed.worst_dd           = rsp_mon.worst_dd;
            observed.dd_peak_idx        = rsp_mon.dd_peak_idx;
            observed.dd_trough_idx      = rsp_mon.dd_trough_idx;
            observed.dd_recovery_idx    = rsp_mon.dd_recovery_idx;
            observed.longest_underwater = rsp_mon.longest_underwater;
            if (expected_words.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT) begin
                  $display("result word with none expected: %s", describe(observed));
               end
            end else begin
               predicted = expected_words.pop_front();
               if (observed !== predicted) begin
                  failures++;
                  if (failures <= REPORT_LIMIT) begin
                     $display("result word mismatch at %0t", $realtime);
                     $display("   expected %s", describe(predicted));
                     $display("   actual   %s", describe(observed));
                  end
               end
            end
         end
      end
      error_count   <= failures;
      words_pending <= expected_words.size();
   end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the drawdown tracker testbench: clock, reset, sample stimulus and result
// back-pressure, with the verdict. Depends on mdt_pkg, mdt_if, max_drawdown_tracker
// and mdt_drawdown_check.
module tb_top;
   import mdt_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RESET_CYCLES  = 6;
   localparam int RANDOM_WORDS  = 1000;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 40;
   localparam int DIRECTED_SIZE = 22;

   logic clock        = 1'b0;
   logic reset        = 1'b1;
   logic hold_results = 1'b0;
   bit   send_calm    = 1'b0;
   int   error_count;
   int   words_pending;
   int   words_sent   = 0;

   // A zero sample below a nonzero peak, a drawdown too small to register, a deeper
   // trough from the same peak and recoveries exactly at the peak are all covered.
   equity_type directed_levels[DIRECTED_SIZE] = '{
      32'd0, 32'd0, 32'd100, 32'd50, 32'd49, 32'd100, 32'd200, 32'hFFFF_FFFF,
      32'hFFFF_FFFE, 32'd0, 32'hFFFF_FFFF, 32'd1000, 32'd999, 32'd998, 32'd500,
      32'd700, 32'd1000, 32'd5, 32'd0, 32'd7, 32'd1, 32'd0
   };
   bit directed_first[DIRECTED_SIZE] = '{
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
      1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0
   };

   mdt_req_if req_ch();
   mdt_rsp_if rsp_ch();

   max_drawdown_tracker uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   mdt_drawdown_check drawdown_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .error_count   (error_count),
      .words_pending (words_pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int pick_gap(input bit calm);
      int roll;
      if (calm) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
         return 0;
      end
      if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      if (roll < 98) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 80);
   endfunction

   task automatic send_word(input equity_type level, input logic first);
      int gap;
      if (words_sent % 40 == 0) begin
         send_calm = ($urandom_range(0, 3) == 0);
      end
      gap = pick_gap(send_calm);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.equity       <= level;
      req_ch.first_sample <= first;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic pause_until_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (words_pending != 0);
      @(negedge clock);
   endtask

   // One equity curve: a random walk around a start level, with occasional returns
   // to the curve's high, wild samples and stray curve restarts mixed in.
   task automatic send_curve();
      int                   length;
      int                   roll;
      equity_type           level;
      equity_type           high_level;
      int unsigned          scale;
      int unsigned          delta;
      logic [EQUITY_BITS:0] raised;
      length = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 30);
      case ($urandom_range(0, 3))
         0: level = $urandom();
         1: level = $urandom_range(0, 255);
         2: level = 32'hFFFF_FF00 | $urandom_range(0, 255);
         default: level = $urandom() >> $urandom_range(0, 31);
      endcase
      scale = level >> $urandom_range(1, 8);
      if (scale == 0) begin
         scale = 4;
      end
      high_level = level;
      send_word(level, $urandom_range(0, 7) != 0);
      for (int i = 1; i < length; i++) begin
         roll = $urandom_range(0, 19);
         if (roll == 0) begin
            level = $urandom();
         end else if (roll == 1) begin
            level = high_level;
         end else begin
            delta = $urandom_range(0, scale);
            if ($urandom_range(0, 1) == 1) begin
               raised = level + delta;
               level  = raised[EQUITY_BITS] ? '1 : raised[EQUITY_BITS-1:0];
            end else begin
               level = (delta > level) ? '0 : level - delta;
            end
         end
         if (level > high_level) begin
            high_level = level;
         end
         send_word(level, $urandom_range(0, 39) == 0);
      end
   endtask

   initial begin
      int  gap;
      int  cycle_index;
      bit  calm;
      bit  hold_done;
      cycle_index = 0;
      calm        = 1'b0;
      hold_done   = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (cycle_index % 40 == 0) begin
            calm = ($urandom_range(0, 3) == 0);
         end
         cycle_index++;
         if (hold_results && !hold_done) begin
            hold_done = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            gap = pick_gap(calm);
            if (gap > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (gap - 1) @(negedge clock);
            end else begin
               rsp_ch.ready <= 1'b1;
            end
         end
      end
   end

   initial begin
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      req_ch.valid        = 1'b0;
      req_ch.equity       = '0;
      req_ch.first_sample = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed_levels[i]) begin
         send_word(directed_levels[i], directed_first[i]);
      end
      pause_until_drained();
      hold_results <= 1'b1;
      while (words_sent < DIRECTED_SIZE + RANDOM_WORDS) begin
         send_curve();
      end
      pause_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
